@@ sv/oist_pkg.sv @@
// Package for the ordered integer set table: sizes, command codes, FSM states,
// payload and memory request structs, and small element helpers.
// No dependencies.
`timescale 1ns / 1ps

package oist_pkg;

  // Store geometry
  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 31;
  localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  // Width of the offset sum: element or 32-bit offset plus sign and carry
  localparam int SUM_BITS = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 2;

  localparam logic [CNT_BITS-1:0] CAP_COUNT = CNT_BITS'(CAPACITY);
  localparam logic [63:0] MAX_ELEM = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic signed [31:0] NO_VALUE = -32'sd1;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_OFFSET  = 3'd3,
    CMD_RESTART = 3'd4,
    CMD_NEXT    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT,
    ST_OFFSET,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef logic [VALUE_BITS-1:0] elem_t;

  // One result item
  typedef struct packed {
    logic signed [31:0]  value;
    logic [CNT_BITS-1:0] count;
    logic                full_drop;
  } res_t;

  // Element store access for one cycle
  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] waddr;
    elem_t               wdata;
    logic                re;
    logic [IDX_BITS-1:0] raddr;
  } mem_req_t;

  // True when a 32-bit input number is a legal element
  function automatic logic elem_ok(input logic signed [31:0] number);
    logic [63:0] wide;
    wide = 64'(number[30:0]);
    return !number[31] && (wide <= MAX_ELEM);
  endfunction

  // Element taken from a legal input number
  function automatic elem_t to_elem(input logic signed [31:0] number);
    logic [63:0] wide;
    wide = 64'(number[30:0]);
    return wide[VALUE_BITS-1:0];
  endfunction

  // Low 32 bits of an element, zero extended where it is narrower
  function automatic logic signed [31:0] low32(input elem_t e);
    logic [VALUE_BITS+31:0] wide;
    wide = {32'd0, e};
    return signed'(wide[31:0]);
  endfunction

endpackage

@@ sv/oist_in_if.sv @@
// Command channel of the ordered integer set table: valid/ready plus fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface oist_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic signed [31:0] number;
  logic signed [31:0] offset;

  modport source (output valid, output cmd, output number, output offset, input ready);
  modport sink   (input valid, input cmd, input number, input offset, output ready);
endinterface

@@ sv/oist_out_if.sv @@
// Result channel of the ordered integer set table: valid/ready plus fields.
// Depends on oist_pkg for the count width.
`timescale 1ns / 1ps

interface oist_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [31:0]            value;
  logic [oist_pkg::CNT_BITS-1:0] count;
  logic                          full_drop;

  modport source (output valid, output value, output count, output full_drop, input ready);
  modport sink   (input valid, input value, input count, input full_drop, output ready);
endinterface

@@ sv/oist_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module oist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read of the address being written returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/oist_out_reg.sv @@
// Output register of the ordered integer set table: holds one result until
// the result channel takes it. Depends on oist_pkg and oist_out_if.
`timescale 1ns / 1ps

module oist_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  oist_pkg::res_t     res,
  output logic               free,
  oist_out_if.source         rsp
);

  logic           valid;
  oist_pkg::res_t data;

  assign free = !valid || rsp.ready;

  // Hold the result until transfer, take a new one when the slot frees
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= res;
    end
  end

  assign rsp.valid     = valid;
  assign rsp.value     = data.value;
  assign rsp.count     = data.count;
  assign rsp.full_drop = data.full_drop;

endmodule

@@ sv/oist_ctrl.sv @@
// Command sequencer of the ordered integer set table: decodes commands, scans,
// shifts and rewrites the element store through one read and one write port.
// Depends on oist_pkg and oist_in_if.
`timescale 1ns / 1ps

module oist_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  oist_in_if.sink               req,
  output oist_pkg::mem_req_t    mem,
  input  oist_pkg::elem_t       rdata,
  output oist_pkg::res_t        res,
  output logic                  res_load,
  input  logic                  res_free
);

  localparam int CB = oist_pkg::CNT_BITS;
  localparam int IB = oist_pkg::IDX_BITS;
  localparam int SB = oist_pkg::SUM_BITS;
  localparam int VB = oist_pkg::VALUE_BITS;

  oist_pkg::state_t state, state_next;
  oist_pkg::cmd_t   op, op_next;
  oist_pkg::elem_t  key, key_next;
  logic signed [31:0] offs, offs_next;
  logic [CB-1:0]    count, count_next;
  logic             iter_valid, iter_valid_next;
  logic [CB-1:0]    iter_pos, iter_pos_next;
  logic [CB-1:0]    ptr, ptr_next;
  logic             rd_pending, rd_pending_next;
  logic [IB-1:0]    rd_idx, rd_idx_next;
  logic [CB-1:0]    kept, kept_next;
  logic signed [31:0] res_value, res_value_next;
  logic             res_drop, res_drop_next;

  logic             accept;
  logic             in_ok;
  logic             hit;
  logic             more;
  logic signed [SB-1:0] sum;
  logic             sum_fits;

  assign req.ready = (state == oist_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_ok     = oist_pkg::elem_ok(req.number);
  assign hit       = rd_pending && (rdata == key);
  assign more      = (ptr < count);

  // Element plus offset, kept when it is non-negative and fits an element
  assign sum = signed'(SB'(rdata)) + SB'(offs);
  assign sum_fits = !sum[SB-1] && ((sum[SB-2:0] >> VB) == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      oist_pkg::ST_IDLE: begin
        if (accept) begin
          priority if ((req.cmd == oist_pkg::CMD_ADD || req.cmd == oist_pkg::CMD_DELETE)
                       && in_ok) begin
            state_next = oist_pkg::ST_FIND;
          end else if (req.cmd == oist_pkg::CMD_OFFSET && count != '0) begin
            state_next = oist_pkg::ST_OFFSET;
          end else if (req.cmd == oist_pkg::CMD_NEXT && iter_valid && iter_pos < count) begin
            state_next = oist_pkg::ST_FETCH;
          end else begin
            state_next = oist_pkg::ST_DONE;
          end
        end
      end
      oist_pkg::ST_FIND: begin
        priority if (hit) begin
          state_next = (op == oist_pkg::CMD_DELETE) ? oist_pkg::ST_SHIFT : oist_pkg::ST_DONE;
        end else if (!more && !rd_pending) begin
          state_next = oist_pkg::ST_DONE;
        end else begin
          state_next = oist_pkg::ST_FIND;
        end
      end
      oist_pkg::ST_SHIFT, oist_pkg::ST_OFFSET: begin
        if (!more && !rd_pending) begin
          state_next = oist_pkg::ST_DONE;
        end
      end
      oist_pkg::ST_FETCH: begin
        state_next = oist_pkg::ST_DONE;
      end
      oist_pkg::ST_DONE: begin
        if (res_free) begin
          state_next = oist_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = oist_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and store accesses
  always_comb begin
    op_next         = op;
    key_next        = key;
    offs_next       = offs;
    count_next      = count;
    iter_valid_next = iter_valid;
    iter_pos_next   = iter_pos;
    ptr_next        = ptr;
    rd_pending_next = 1'b0;
    rd_idx_next     = rd_idx;
    kept_next       = kept;
    res_value_next  = res_value;
    res_drop_next   = res_drop;
    mem.we          = 1'b0;
    mem.waddr       = '0;
    mem.wdata       = rdata;
    mem.re          = 1'b0;
    mem.raddr       = ptr[IB-1:0];
    res_load        = 1'b0;

    unique case (state)
      oist_pkg::ST_IDLE: begin
        if (accept) begin
          op_next        = oist_pkg::cmd_t'(req.cmd);
          key_next       = oist_pkg::to_elem(req.number);
          offs_next      = req.offset;
          ptr_next       = '0;
          kept_next      = '0;
          res_value_next = oist_pkg::NO_VALUE;
          res_drop_next  = 1'b0;
          unique case (req.cmd)
            oist_pkg::CMD_ADD, oist_pkg::CMD_DELETE: begin
              iter_valid_next = 1'b0;
            end
            oist_pkg::CMD_CLEAR: begin
              count_next      = '0;
              iter_valid_next = 1'b0;
              iter_pos_next   = '0;
            end
            oist_pkg::CMD_RESTART: begin
              iter_valid_next = 1'b1;
              iter_pos_next   = '0;
            end
            oist_pkg::CMD_NEXT: begin
              // Fetch the current element, or close the walk at the end
              if (iter_valid && iter_pos < count) begin
                mem.re    = 1'b1;
                mem.raddr = iter_pos[IB-1:0];
              end else if (iter_valid) begin
                iter_valid_next = 1'b0;
                iter_pos_next   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      oist_pkg::ST_FIND: begin
        if (hit) begin
          // Found: delete closes the gap starting after the match
          ptr_next = CB'(rd_idx) + CB'(1);
        end else if (more) begin
          mem.re          = 1'b1;
          rd_idx_next     = ptr[IB-1:0];
          ptr_next        = ptr + CB'(1);
          rd_pending_next = 1'b1;
        end else if (!rd_pending && op == oist_pkg::CMD_ADD) begin
          // Absent: append, or drop when full
          if (count >= oist_pkg::CAP_COUNT) begin
            res_drop_next = 1'b1;
          end else begin
            mem.we     = 1'b1;
            mem.waddr  = count[IB-1:0];
            mem.wdata  = key;
            count_next = count + CB'(1);
          end
        end
      end

      oist_pkg::ST_SHIFT: begin
        // Move each later element down by one slot
        if (rd_pending) begin
          mem.we    = 1'b1;
          mem.waddr = rd_idx - IB'(1);
        end
        if (more) begin
          mem.re          = 1'b1;
          rd_idx_next     = ptr[IB-1:0];
          ptr_next        = ptr + CB'(1);
          rd_pending_next = 1'b1;
        end else if (!rd_pending) begin
          count_next = count - CB'(1);
        end
      end

      oist_pkg::ST_OFFSET: begin
        // Rewrite shifted elements in order, dropping those out of range
        if (rd_pending && sum_fits) begin
          mem.we    = 1'b1;
          mem.waddr = kept[IB-1:0];
          mem.wdata = sum[VB-1:0];
          kept_next = kept + CB'(1);
        end
        if (more) begin
          mem.re          = 1'b1;
          ptr_next        = ptr + CB'(1);
          rd_pending_next = 1'b1;
        end else if (!rd_pending) begin
          count_next      = kept;
          iter_valid_next = 1'b1;
          iter_pos_next   = '0;
        end
      end

      oist_pkg::ST_FETCH: begin
        res_value_next = oist_pkg::low32(rdata);
        iter_pos_next  = iter_pos + CB'(1);
      end

      oist_pkg::ST_DONE: begin
        res_load = 1'b1;
      end

      default: begin
      end
    endcase
  end

  assign res.value     = res_value;
  assign res.count     = count;
  assign res.full_drop = res_drop;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= oist_pkg::ST_IDLE;
      count      <= '0;
      iter_valid <= 1'b0;
      iter_pos   <= '0;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      iter_valid <= iter_valid_next;
      iter_pos   <= iter_pos_next;
      rd_pending <= rd_pending_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op        <= op_next;
    key       <= key_next;
    offs      <= offs_next;
    ptr       <= ptr_next;
    rd_idx    <= rd_idx_next;
    kept      <= kept_next;
    res_value <= res_value_next;
    res_drop  <= res_drop_next;
  end

endmodule

@@ sv/ordered_integer_set_table.sv @@
// Top level of the ordered integer set table. Depends on oist_pkg, the two
// channel interfaces, oist_ram, oist_ctrl and oist_out_reg.
`timescale 1ns / 1ps

// Holds up to CAPACITY distinct non-negative values in insertion order in one
// RAM, and answers every command with exactly one result. Commands are taken
// one at a time; the element store has a single read and a single write port,
// so any command that walks the store touches one entry per cycle. With N
// elements held: clear, restart, unknown codes, add or delete of an illegal
// number, add offset on an empty store and a next that returns -1 do not walk
// the store, and a next that returns an element reads a single entry. The
// search of add and delete stops at a match, and an absent value is looked for
// in all N entries. Delete then moves each element behind the match down by
// one slot. Add offset on a non-empty store reads all N entries. A finished
// result sits in an output register, so the next command is taken while the
// previous result waits for transfer.

module ordered_integer_set_table (
  input  logic        clk,
  input  logic        rst,
  oist_in_if.sink     req,
  oist_out_if.source  rsp
);

  oist_pkg::mem_req_t mem;
  oist_pkg::elem_t    rdata;
  oist_pkg::res_t     res;
  logic               res_load;
  logic               res_free;

  oist_ram #(
    .WIDTH (oist_pkg::VALUE_BITS),
    .DEPTH (oist_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  oist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .mem      (mem),
    .rdata    (rdata),
    .res      (res),
    .res_load (res_load),
    .res_free (res_free)
  );

  oist_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (res_load),
    .res  (res),
    .free (res_free),
    .rsp  (rsp)
  );

endmodule
